// ----- sv/ptt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic task table: request and status
// codes, the sequencer states and the layout of one stored table entry.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Request codes.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t STATUS_ADDED = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_FIRED = 2'd2;
    localparam status_t STATUS_NONE  = 2'd3;

    // A freshly added task starts with a last-fire time of minus one.
    localparam logic [31:0] LAST_FIRE_INIT = 32'hFFFF_FFFF;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_DONE
    } state_t;

    // One table entry as it is held in the entry memory.
    typedef struct packed {
        logic [7:0]  task_id;
        logic [30:0] period;
        logic [31:0] last_fire;
    } entry_t;

endpackage

// ----- sv/periodic_task_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_table_top
// Several independent tables of periodic tasks. Add requests place a task in
// the lowest free slot of a table; tick requests scan a table and fire every
// task whose interval has run out since it last fired.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Word
//  --------  --------------------  ----------------------------------------
//  request   req_valid, req_stall  req_type, pipeline, task_id, period_ms,
//                                  now_ms
//  response  rsp_valid, rsp_stall  status, slot, fired_id, last
//
// The block works on one request at a time. An add walks the valid bits of
// its table one slot per cycle, up to the last slot when the table turns out
// to be full. A tick streams every slot of its table out of the entry memory,
// one slot per cycle while no new fire is held back by a stalled response;
// the single read port of the entry memory feeds the compare stage.
// Reset clears the sequencer and the per-entry valid bits at once, so the
// block is ready right after reset with no clearing pass.
// A stalled response holds the scan only when a new fire is found while an
// earlier one is held and the output register still waits to be taken.
// ----------------------------------------------------------------------------
module periodic_task_table_top #(
    parameter int SLOTS     = 16,
    parameter int PIPELINES = 3
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             req_valid,
    output logic             req_stall,
    input  logic             req_type,
    input  logic [1:0]       pipeline,
    input  logic [7:0]       task_id,
    input  logic [30:0]      period_ms,
    input  logic [30:0]      now_ms,

    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ptt_pkg::status_t status,
    output logic [3:0]       slot,
    output logic [7:0]       fired_id,
    output logic             last
);

    import ptt_pkg::*;

    localparam int NENTRY = SLOTS * PIPELINES;
    localparam int ENT_W  = (NENTRY > 1) ? $clog2(NENTRY) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = $bits(entry_t);

    // Sequencer and request registers.
    state_t            state_reg, state_next;
    logic              type_reg, type_next;
    logic [1:0]        pipe_reg, pipe_next;
    logic [7:0]        id_reg, id_next;
    logic [30:0]       period_reg, period_next;
    logic [30:0]       now_reg, now_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Per-entry valid bits.
    logic [NENTRY-1:0] valid_reg, valid_next;

    // Compare stage of the tick scan.
    logic              ev_valid_reg, ev_valid_next;
    logic [SLOT_W-1:0] ev_slot_reg, ev_slot_next;

    // The most recent fire, held until we know whether it is the final one.
    logic              hold_valid_reg, hold_valid_next;
    logic [SLOT_W-1:0] hold_slot_reg, hold_slot_next;
    logic [7:0]        hold_id_reg, hold_id_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [3:0]        out_slot_reg, out_slot_next;
    logic [7:0]        out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;

    // Entry memory ports.
    logic              ram_wr_en;
    logic [ENT_W-1:0]  ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [ENT_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_word;
    entry_t            rd_entry;

    logic              accept;
    logic              in_range;
    logic              out_free;
    logic [ENT_W-1:0]  base_idx;
    logic [ENT_W-1:0]  cnt_idx;
    logic [ENT_W-1:0]  ev_idx;
    logic              cnt_last;
    logic              cnt_end;
    logic              add_hit;
    logic              ev_fire;
    logic              ev_block;
    logic              tick_adv;
    logic signed [32:0] fire_limit;
    logic signed [32:0] now_ext;
    logic [7:0]        cnt_slot8;
    logic [7:0]        hold_slot8;

    ptt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NENTRY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_word)
    );

    assign rd_entry = entry_t'(ram_rd_word);

    // The request side is open only between requests.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_range  = (int'(pipeline) < PIPELINES);
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Entry addressing: each table owns SLOTS consecutive entries.
    assign base_idx = ENT_W'(int'(pipe_reg) * SLOTS);
    assign cnt_idx  = base_idx + ENT_W'(cnt_reg);
    assign ev_idx   = base_idx + ENT_W'(ev_slot_reg);
    assign cnt_last = (cnt_reg == CNT_W'(SLOTS - 1));
    assign cnt_end  = (cnt_reg == CNT_W'(SLOTS));

    // During an add the counter never passes the last slot.
    assign add_hit = !valid_reg[cnt_idx];

    // The limit is formed at 33 bits with a signed last-fire time, so it
    // never wraps.
    assign fire_limit = $signed({rd_entry.last_fire[31], rd_entry.last_fire})
                      + $signed({2'b00, rd_entry.period});
    assign now_ext    = $signed({2'b00, now_reg});
    assign ev_fire    = ev_valid_reg && valid_reg[ev_idx] && (now_ext > fire_limit);

    // A new fire needs the held one pushed out first.
    assign ev_block = ev_fire && hold_valid_reg && !out_free;
    assign tick_adv = !ev_block;

    assign cnt_slot8  = 8'(cnt_reg[SLOT_W-1:0]);
    assign hold_slot8 = 8'(hold_slot_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (req_type == REQ_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                if (add_hit && out_free)
                begin
                    state_next = ST_IDLE;
                end
                else if (!add_hit && cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK:
            begin
                if (cnt_end && tick_adv)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result generation.
    always_comb
    begin
        type_next       = type_reg;
        pipe_next       = pipe_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        now_next        = now_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        ev_valid_next   = ev_valid_reg;
        ev_slot_next    = ev_slot_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_id_next    = hold_id_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_idx;
        ram_wr_data = '{task_id: id_reg, period: period_reg, last_fire: LAST_FIRE_INIT};
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_idx;

        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    type_next       = req_type;
                    pipe_next       = pipeline;
                    id_next         = task_id;
                    period_next     = period_ms;
                    now_next        = now_ms;
                    cnt_next        = '0;
                    ev_valid_next   = 1'b0;
                    hold_valid_next = 1'b0;
                end
            end
            ST_ADD:
            begin
                if (add_hit)
                begin
                    if (out_free)
                    begin
                        ram_wr_en           = 1'b1;
                        valid_next[cnt_idx] = 1'b1;
                        out_valid_next      = 1'b1;
                        out_status_next     = STATUS_ADDED;
                        out_slot_next       = cnt_slot8[3:0];
                        out_id_next         = id_reg;
                        out_last_next       = 1'b1;
                    end
                end
                else if (!cnt_last)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_TICK:
            begin
                if (ev_fire && tick_adv)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ev_idx;
                    ram_wr_data = '{task_id: rd_entry.task_id, period: rd_entry.period,
                                    last_fire: {1'b0, now_reg}};
                    if (hold_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_FIRED;
                        out_slot_next   = hold_slot8[3:0];
                        out_id_next     = hold_id_reg;
                        out_last_next   = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_slot_next  = ev_slot_reg;
                    hold_id_next    = rd_entry.task_id;
                end
                if (tick_adv)
                begin
                    if (!cnt_end)
                    begin
                        ram_rd_en     = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_slot_next  = cnt_reg[SLOT_W-1:0];
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    if (type_reg == REQ_TICK && hold_valid_reg)
                    begin
                        out_status_next = STATUS_FIRED;
                        out_slot_next   = hold_slot8[3:0];
                        out_id_next     = hold_id_reg;
                    end
                    else
                    begin
                        out_status_next = (type_reg == REQ_TICK) ? STATUS_NONE : STATUS_FULL;
                        out_slot_next   = '0;
                        out_id_next     = '0;
                    end
                end
            end
            default:
            begin
                ev_valid_next   = 1'b0;
                hold_valid_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            ev_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            ev_valid_reg   <= ev_valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        pipe_reg       <= pipe_next;
        id_reg         <= id_next;
        period_reg     <= period_next;
        now_reg        <= now_next;
        ev_slot_reg    <= ev_slot_next;
        hold_slot_reg  <= hold_slot_next;
        hold_id_reg    <= hold_id_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign slot      = out_slot_reg;
    assign fired_id  = out_id_reg;
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    // An accepted request always starts a sequence.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // The compare stage is only occupied during a tick scan.
    a_ev_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> state_reg == ST_TICK)
        else $error("compare stage valid outside a tick");

    // An add never leaves a held fire behind.
    a_add_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD |-> !hold_valid_reg)
        else $error("held fire during an add");

    // Only fires can be followed by further results of the same request.
    a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> status == STATUS_FIRED)
        else $error("non-final result that is not a fire");

    // Adds answer with exactly one result.
    a_added_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_ADDED |-> last)
        else $error("add result without final flag");
`endif

endmodule

// ----- sv/ptt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
